// File: hw/rtl/prq_pkg.sv
// ----------------------------------------------------------------------------
// prq_pkg
// shared types and codes of the priority ready queue
// ----------------------------------------------------------------------------
package prq_pkg;

  // number of priority levels, 1..LEVELS, LEVELS highest
  localparam int LEVELS = 4;
  localparam int LVL_W  = $clog2(LEVELS);

  // payload field widths
  localparam int OP_W     = 1;
  localparam int TASK_W   = 5;
  localparam int PRIO_W   = 3;
  localparam int STATUS_W = 2;

  // stream data widths, rounded up to whole bytes
  localparam int IN_FIELDS_W  = OP_W + TASK_W + PRIO_W;
  localparam int OUT_FIELDS_W = STATUS_W + TASK_W + PRIO_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // operation codes
  localparam logic [OP_W-1:0] OP_ENQ = 1'b0;
  localparam logic [OP_W-1:0] OP_DEQ = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_BADPRIO = 2'd3
  } status_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_READ = 1'b1
  } fsm_state_t;

  // bookkeeping command from the controller to the level registers
  typedef struct packed {
    logic             enq;
    logic             deq;
    logic [LVL_W-1:0] lv;
  } lvl_cmd_t;

  // level status back to the controller
  typedef struct packed {
    logic              any_ready;
    logic [LVL_W-1:0]  top_lv;
    logic [LEVELS-1:0] full;
  } lvl_stat_t;

endpackage

// File: hw/rtl/prq_ram.sv
// ----------------------------------------------------------------------------
// prq_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module prq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/prq_levels.sv
// ----------------------------------------------------------------------------
// prq_levels
// head, tail and fill count of each level, priority pick and ram addresses
// ----------------------------------------------------------------------------
module prq_levels #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  prq_pkg::lvl_cmd_t     cmd,
  output prq_pkg::lvl_stat_t    stat,
  output logic [$clog2(prq_pkg::LEVELS*QUEUE_DEPTH)-1:0] wr_addr,
  output logic [$clog2(prq_pkg::LEVELS*QUEUE_DEPTH)-1:0] rd_addr
);

  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W = $clog2(prq_pkg::LEVELS * QUEUE_DEPTH);

  logic [IDX_W-1:0] head_r  [prq_pkg::LEVELS];
  logic [IDX_W-1:0] tail_r  [prq_pkg::LEVELS];
  logic [CNT_W-1:0] count_r [prq_pkg::LEVELS];

  logic [IDX_W-1:0]  tail_nxt;
  logic [IDX_W-1:0]  head_nxt;
  logic [ADDR_W-1:0] base;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
    if (idx == IDX_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return idx + IDX_W'(1);
  endfunction

  // highest non-empty level wins
  always_comb begin
    stat.any_ready = 1'b0;
    stat.top_lv    = '0;
    for (int i = 0; i < prq_pkg::LEVELS; i++) begin
      stat.full[i] = (count_r[i] == CNT_W'(QUEUE_DEPTH));
      if (count_r[i] != '0) begin
        stat.any_ready = 1'b1;
        stat.top_lv    = prq_pkg::LVL_W'(i);
      end
    end
  end

  assign tail_nxt = wrap_inc(tail_r[cmd.lv]);
  assign head_nxt = wrap_inc(head_r[cmd.lv]);
  assign base     = ADDR_W'(cmd.lv) * ADDR_W'(QUEUE_DEPTH);
  assign wr_addr  = base + ADDR_W'(tail_nxt);
  assign rd_addr  = base + ADDR_W'(head_r[cmd.lv]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < prq_pkg::LEVELS; i++) begin
        head_r[i]  <= '0;
        tail_r[i]  <= IDX_W'(QUEUE_DEPTH - 1);
        count_r[i] <= '0;
      end
    end else if (cmd.enq) begin
      tail_r[cmd.lv]  <= tail_nxt;
      count_r[cmd.lv] <= count_r[cmd.lv] + CNT_W'(1);
    end else if (cmd.deq) begin
      head_r[cmd.lv]  <= head_nxt;
      count_r[cmd.lv] <= count_r[cmd.lv] - CNT_W'(1);
    end
  end

endmodule

// File: hw/rtl/priority_ready_queue.sv
// ----------------------------------------------------------------------------
// priority_ready_queue
// strict-priority ready queue of task identifiers, one fifo per level
// ----------------------------------------------------------------------------
// usage:
//   in_* carries one operation per transaction: enqueue a task at the tail
//   of its level, or dequeue the head of the highest non-empty level.
//   out_* returns exactly one result per operation, in order: a status code,
//   the task handled and its level.
//   an enqueue result is registered in the cycle after acceptance; a dequeue
//   result passes the registered store ram read, then the result register.
//   sustained rate: one enqueue per cycle while results are taken; each
//   operation, a dequeue's store read too, is finished before the next is taken.
//   refused enqueues (invalid level, level full) and a dequeue with all
//   levels empty answer without a store read and change no state.
//   reset (rst_n low, synchronous) empties all levels at once; the store
//   itself needs no clearing, only written slots are ever read.
//   when the receiver stalls, the result waits in the output register and
//   in_tready drops until it is taken; a result taken in the same cycle
//   lets a new operation in.
// ----------------------------------------------------------------------------
module priority_ready_queue #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // fields from bit 0: operation[0], task_id[5:1], priority_req[8:6], zeros
  input  logic [prq_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // fields from bit 0: status[1:0], out_task_id[6:2], out_priority[9:7], zeros
  output logic [prq_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int ADDR_W = $clog2(prq_pkg::LEVELS * QUEUE_DEPTH);

  // input field split
  logic [prq_pkg::OP_W-1:0]   in_op;
  logic [prq_pkg::TASK_W-1:0] in_task;
  logic [prq_pkg::PRIO_W-1:0] in_prio;

  assign in_op   = in_tdata[0];
  assign in_task = in_tdata[prq_pkg::TASK_W:1];
  assign in_prio = in_tdata[prq_pkg::OP_W+prq_pkg::TASK_W +: prq_pkg::PRIO_W];

  // control state
  prq_pkg::fsm_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;

  // result register and pending dequeue level
  prq_pkg::status_t           res_status_r, res_status_nxt;
  logic [prq_pkg::TASK_W-1:0] res_task_r, res_task_nxt;
  logic [prq_pkg::PRIO_W-1:0] res_prio_r, res_prio_nxt;
  logic [prq_pkg::PRIO_W-1:0] pend_prio_r, pend_prio_nxt;

  // handshake and decode
  logic                       accept;
  logic                       out_free;
  logic                       prio_ok;
  logic [prq_pkg::LVL_W-1:0]  enq_lv;
  logic                       read_done;

  // level bookkeeping and ram
  prq_pkg::lvl_cmd_t          cmd;
  prq_pkg::lvl_stat_t         stat;
  logic [ADDR_W-1:0]          wr_addr;
  logic [ADDR_W-1:0]          rd_addr;
  logic                       ram_we;
  logic                       ram_re;
  logic [prq_pkg::TASK_W-1:0] ram_rdata;

  assign out_free = !out_valid_r || out_tready;
  assign accept   = in_tvalid && in_tready;
  assign prio_ok  = (in_prio != '0) && (in_prio <= prq_pkg::PRIO_W'(prq_pkg::LEVELS));
  assign enq_lv   = prq_pkg::LVL_W'(in_prio - prq_pkg::PRIO_W'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      prq_pkg::FSM_IDLE: begin
        if (accept && in_op == prq_pkg::OP_DEQ && stat.any_ready) begin
          state_nxt = prq_pkg::FSM_READ;
        end
      end
      prq_pkg::FSM_READ: begin
        state_nxt = prq_pkg::FSM_IDLE;
      end
      default: begin
        state_nxt = prq_pkg::FSM_IDLE;
      end
    endcase
  end

  // fsm outputs
  always_comb begin
    in_tready = 1'b0;
    read_done = 1'b0;
    case (state_r)
      prq_pkg::FSM_IDLE: begin
        in_tready = out_free;
      end
      prq_pkg::FSM_READ: begin
        read_done = 1'b1;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // operation decode, level commands and result selection
  always_comb begin
    cmd            = '0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    out_valid_nxt  = out_valid_r && !out_tready;
    res_status_nxt = res_status_r;
    res_task_nxt   = res_task_r;
    res_prio_nxt   = res_prio_r;
    pend_prio_nxt  = pend_prio_r;

    if (read_done) begin
      // store data for the dequeue issued last cycle
      out_valid_nxt  = 1'b1;
      res_status_nxt = prq_pkg::ST_OK;
      res_task_nxt   = ram_rdata;
      res_prio_nxt   = pend_prio_r;
    end else if (accept) begin
      out_valid_nxt = 1'b1;
      res_task_nxt  = '0;
      res_prio_nxt  = '0;
      if (in_op == prq_pkg::OP_ENQ) begin
        cmd.lv = enq_lv;
        if (!prio_ok) begin
          res_status_nxt = prq_pkg::ST_BADPRIO;
        end else if (stat.full[enq_lv]) begin
          res_status_nxt = prq_pkg::ST_FULL;
        end else begin
          cmd.enq        = 1'b1;
          ram_we         = 1'b1;
          res_status_nxt = prq_pkg::ST_OK;
          res_task_nxt   = in_task;
          res_prio_nxt   = in_prio;
        end
      end else begin
        cmd.lv = stat.top_lv;
        if (!stat.any_ready) begin
          res_status_nxt = prq_pkg::ST_EMPTY;
        end else begin
          // result comes next cycle from the ram
          out_valid_nxt = 1'b0;
          cmd.deq       = 1'b1;
          ram_re        = 1'b1;
          pend_prio_nxt = prq_pkg::PRIO_W'(stat.top_lv) + prq_pkg::PRIO_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= prq_pkg::FSM_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    res_task_r   <= res_task_nxt;
    res_prio_r   <= res_prio_nxt;
    pend_prio_r  <= pend_prio_nxt;
  end

  prq_levels #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_levels (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .stat   (stat),
    .wr_addr(wr_addr),
    .rd_addr(rd_addr)
  );

  prq_ram #(
    .WIDTH(prq_pkg::TASK_W),
    .DEPTH(prq_pkg::LEVELS * QUEUE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_addr),
    .wdata(in_task),
    .re   (ram_re),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {
    {(prq_pkg::OUT_DATA_W - prq_pkg::OUT_FIELDS_W){1'b0}},
    res_prio_r, res_task_r, res_status_r
  };

  // a dequeue read is always followed by the read-data state
  a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |=> state_r == prq_pkg::FSM_READ)
    else $error("ram read not followed by read state");

  // the output register is free while the store data is in flight
  a_out_free_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == prq_pkg::FSM_READ |-> !out_valid_r)
    else $error("output register busy during store read");

  // store write and read never fall in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("store read and write overlap");

  // an ok result always names a level, a refused one never does
  a_prio_vs_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((res_status_r == prq_pkg::ST_OK) == (res_prio_r != '0)))
    else $error("result level inconsistent with status");

endmodule
